### rtl/tgrm_pkg.sv
// ----------------------------------------------------------------------------
// tgrm_pkg: shared types and constants of the tile grid rectangle merger
// Register indexes, fixed field widths and the small control structs that
// pass between the front end, the flush queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tgrm_pkg;

    localparam int OUT_W     = 6;   // width of every coordinate on the result beat
    localparam int CFG_W     = 7;   // width of the configuration registers
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // One row end, handed from the front end to the back end.
    typedef struct packed {
        logic last;     // final row of the grid: close every rectangle
        logic bank;     // run table bank that holds this row's runs
    } flush_cmd_t;

    // Event tied to one run table bank (run write, bank release).
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_evt_t;

endpackage

`default_nettype wire

### rtl/tgrm_ram.sv
// ----------------------------------------------------------------------------
// tgrm_ram: generic simple dual port RAM
// One write port, one read port, read data registered, no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/tgrm_front.sv
// ----------------------------------------------------------------------------
// tgrm_front: tile intake and run detection
// Holds the grid size registers and the raster position, cuts each row into
// runs, writes finished runs into the current run table bank and posts a
// flush command at every row end. Bank busy flags stall intake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgrm_front #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [tgrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tgrm_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             tile_present,
    output tgrm_pkg::bank_evt_t                   rec,
    output logic [$clog2(MAX_COLUMNS)-1:0]        rec_start,
    output logic [$clog2(MAX_COLUMNS)-1:0]        rec_end,
    output logic                                  push_valid,
    output tgrm_pkg::flush_cmd_t                  push_cmd,
    input  wire tgrm_pkg::bank_evt_t              rel
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WW = CW + 1;
    localparam int HW = RW + 1;

    logic [tgrm_pkg::CFG_W-1:0] grid_width_reg;
    logic [tgrm_pkg::CFG_W-1:0] grid_height_reg;
    logic [CW-1:0]              col_reg,   col_next;
    logic [RW-1:0]              row_reg,   row_next;
    logic                       run_open_reg, run_open_next;
    logic [CW-1:0]              run_start_reg, run_start_next;
    logic                       bank_reg;
    logic [1:0]                 busy_reg,  busy_next;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          accept;
    logic          row_end;
    logic          last_row;
    logic          rec_hit;

    // Out-of-range sizes: zero acts as one, too large acts as the maximum.
    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = WW'(1);
        else if (32'(grid_width_reg) > 32'(MAX_COLUMNS))
            w_eff = WW'(MAX_COLUMNS);
        else
            w_eff = WW'(grid_width_reg);

        if (grid_height_reg == '0)
            h_eff = HW'(1);
        else if (32'(grid_height_reg) > 32'(MAX_ROWS))
            h_eff = HW'(MAX_ROWS);
        else
            h_eff = HW'(grid_height_reg);
    end

    assign in_ready = !busy_reg[bank_reg];
    assign accept   = in_valid && in_ready;
    assign row_end  = ({1'b0, col_reg} + WW'(1)) >= w_eff;
    assign last_row = ({1'b0, row_reg} + HW'(1)) >= h_eff;

    always_comb
    begin
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        rec_hit        = 1'b0;
        rec_start      = run_start_reg;
        rec_end        = col_reg;
        if (tile_present && !run_open_reg)
        begin
            run_open_next  = 1'b1;
            run_start_next = col_reg;
        end
        else if (!tile_present && run_open_reg)
        begin
            rec_hit       = 1'b1;
            rec_end       = col_reg - CW'(1);
            run_open_next = 1'b0;
        end
        // a run still open at the row end closes on the last tile
        if (row_end && run_open_next)
        begin
            rec_hit       = 1'b1;
            rec_start     = run_start_next;
            rec_end       = col_reg;
            run_open_next = 1'b0;
        end

        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (row_end)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + RW'(1);
        end

        busy_next = busy_reg;
        if (rel.valid)
            busy_next[rel.bank] = 1'b0;
        if (push_valid)
            busy_next[bank_reg] = 1'b1;
    end

    assign rec.valid     = accept && rec_hit;
    assign rec.bank      = bank_reg;
    assign push_valid    = accept && row_end;
    assign push_cmd.last = last_row;
    assign push_cmd.bank = bank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= tgrm_pkg::CFG_W'(64);
            grid_height_reg <= tgrm_pkg::CFG_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tgrm_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                tgrm_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:                   grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            bank_reg      <= 1'b0;
            busy_reg      <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (accept)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                run_open_reg  <= run_open_next;
                run_start_reg <= run_start_next;
                if (row_end)
                    bank_reg <= !bank_reg;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/tgrm_queue.sv
// ----------------------------------------------------------------------------
// tgrm_queue: two-entry flush command queue
// Decouples row ends seen by the front end from flushes run by the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgrm_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire tgrm_pkg::flush_cmd_t push_cmd,
    input  wire logic                 pop,
    output logic                      q_valid,
    output tgrm_pkg::flush_cmd_t      q_cmd
);

    tgrm_pkg::flush_cmd_t slot_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg, count_next;

    assign q_valid = count_reg != 2'd0;
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            slot_reg[0] <= '0;
            slot_reg[1] <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                slot_reg[wr_ptr_reg] <= push_cmd;
                wr_ptr_reg           <= !wr_ptr_reg;
            end
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

`ifndef SYNTHESIS
    // each bank has at most one row end in flight, so two slots suffice
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("flush queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("flush queue popped while empty");
`endif

endmodule

`default_nettype wire

### rtl/tgrm_back.sv
// ----------------------------------------------------------------------------
// tgrm_back: rectangle table and flush engine
// Walks every start column once per row end, merges the row's runs into the
// open rectangle table and sends closed rectangles out in column order. A
// one-deep holding stage delays each result so the last one can be flagged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgrm_back #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tgrm_pkg::bank_evt_t                 rec,
    input  wire logic [$clog2(MAX_COLUMNS)-1:0]      rec_start,
    input  wire logic [$clog2(MAX_COLUMNS)-1:0]      rec_end,
    input  wire logic                                q_valid,
    input  wire tgrm_pkg::flush_cmd_t                q_cmd,
    output logic                                     pop,
    output tgrm_pkg::bank_evt_t                      rel,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [tgrm_pkg::OUT_W-1:0]               left_column,
    output logic [tgrm_pkg::OUT_W-1:0]               top_row,
    output logic [tgrm_pkg::OUT_W-1:0]               right_column,
    output logic [tgrm_pkg::OUT_W-1:0]               bottom_row,
    output logic                                     last_of_flush
);

    localparam int CW     = $clog2(MAX_COLUMNS);
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int OW     = CW + 2 * RW;
    localparam int NAW    = CW + 1;
    localparam int NDEPTH = 1 << NAW;
    localparam int FW     = tgrm_pkg::OUT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_SECOND,
        ST_FINISH
    } state_t;

    state_t                       state_reg;
    logic [CW-1:0]                s_reg;
    logic [RW-1:0]                row_reg;
    logic                         last_reg;
    logic                         bank_reg;
    logic [MAX_COLUMNS-1:0]       open_valid_reg;
    logic [1:0][MAX_COLUMNS-1:0]  new_valid_reg;

    logic                         held_valid_reg;
    logic [CW-1:0]                held_left_reg;
    logic [RW-1:0]                held_top_reg;
    logic [CW-1:0]                held_right_reg;
    logic [RW-1:0]                held_bottom_reg;

    logic                         out_valid_reg;
    logic [FW-1:0]                out_left_reg;
    logic [FW-1:0]                out_top_reg;
    logic [FW-1:0]                out_right_reg;
    logic [FW-1:0]                out_bottom_reg;
    logic                         out_last_reg;

    logic [OW-1:0] open_rdata, open_wdata;
    logic [CW-1:0] run_rdata;
    logic          open_we;
    logic          rd_en;
    logic [CW-1:0] rd_col;
    logic          rd_bank;

    logic [CW-1:0] o_right;
    logic [RW-1:0] o_top, o_bottom;
    logic          ov, nv, match;
    logic          cand_a, cand_b;
    logic          out_free, can_push;
    logic          step_go, second_go, finish_go, advance, last_col;
    logic          push_valid;
    logic [RW-1:0] push_top, push_bottom;
    logic [CW-1:0] push_right;

    assign {o_right, o_top, o_bottom} = open_rdata;

    always_comb
    begin
        ov       = open_valid_reg[s_reg];
        nv       = new_valid_reg[bank_reg][s_reg];
        match    = ov && nv && (run_rdata == o_right);
        // old rectangle leaves unless extended; on the last row everything leaves
        cand_a   = ov && (!match || last_reg);
        cand_b   = nv && !match && last_reg;
        out_free = !out_valid_reg || out_ready;
        can_push = !held_valid_reg || out_free;
        last_col = s_reg == CW'(MAX_COLUMNS - 1);

        step_go   = (state_reg == ST_STEP) && (!cand_a || can_push);
        second_go = (state_reg == ST_SECOND) && can_push;
        finish_go = (state_reg == ST_FINISH) && (!held_valid_reg || out_free);
        advance   = (step_go && !cand_b) || second_go;

        pop     = (state_reg == ST_IDLE) && q_valid;
        rd_en   = pop || (advance && !last_col);
        rd_col  = pop ? '0 : s_reg + CW'(1);
        rd_bank = pop ? q_cmd.bank : bank_reg;

        open_we    = step_go && !last_reg && (match || nv);
        open_wdata = match ? {o_right, o_top, row_reg} : {run_rdata, row_reg, row_reg};

        push_valid  = (step_go && cand_a) || second_go;
        push_top    = (state_reg == ST_SECOND) ? row_reg   : o_top;
        push_right  = (state_reg == ST_SECOND) ? run_rdata : o_right;
        push_bottom = (state_reg == ST_SECOND) ? row_reg
                    : (match ? row_reg : o_bottom);

        rel.valid = finish_go;
        rel.bank  = bank_reg;
    end

    tgrm_ram #(
        .WIDTH (OW),
        .DEPTH (MAX_COLUMNS)
    ) u_open_ram (
        .clk   (clk),
        .we    (open_we),
        .waddr (s_reg),
        .wdata (open_wdata),
        .re    (rd_en),
        .raddr (rd_col),
        .rdata (open_rdata)
    );

    tgrm_ram #(
        .WIDTH (CW),
        .DEPTH (NDEPTH)
    ) u_run_ram (
        .clk   (clk),
        .we    (rec.valid),
        .waddr ({rec.bank, rec_start}),
        .wdata (rec_end),
        .re    (rd_en),
        .raddr ({rd_bank, rd_col}),
        .rdata (run_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            s_reg           <= '0;
            row_reg         <= '0;
            last_reg        <= 1'b0;
            bank_reg        <= 1'b0;
            open_valid_reg  <= '0;
            new_valid_reg   <= '0;
            held_valid_reg  <= 1'b0;
            held_left_reg   <= '0;
            held_top_reg    <= '0;
            held_right_reg  <= '0;
            held_bottom_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_left_reg    <= '0;
            out_top_reg     <= '0;
            out_right_reg   <= '0;
            out_bottom_reg  <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            // a new candidate pushes the held one out, not last
            if (push_valid)
            begin
                if (held_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_left_reg   <= FW'(held_left_reg);
                    out_top_reg    <= FW'(held_top_reg);
                    out_right_reg  <= FW'(held_right_reg);
                    out_bottom_reg <= FW'(held_bottom_reg);
                    out_last_reg   <= 1'b0;
                end
                held_valid_reg  <= 1'b1;
                held_left_reg   <= s_reg;
                held_top_reg    <= push_top;
                held_right_reg  <= push_right;
                held_bottom_reg <= push_bottom;
            end

            if (step_go)
            begin
                open_valid_reg[s_reg]          <= !last_reg && (match || nv);
                new_valid_reg[bank_reg][s_reg] <= 1'b0;
            end
            if (rec.valid)
                new_valid_reg[rec.bank][rec_start] <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        last_reg  <= q_cmd.last;
                        bank_reg  <= q_cmd.bank;
                        s_reg     <= '0;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    if (step_go)
                    begin
                        if (cand_b)
                            state_reg <= ST_SECOND;
                        else if (last_col)
                            state_reg <= ST_FINISH;
                        else
                            s_reg <= s_reg + CW'(1);
                    end
                end
                ST_SECOND:
                begin
                    if (second_go)
                    begin
                        if (last_col)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            s_reg     <= s_reg + CW'(1);
                            state_reg <= ST_STEP;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (finish_go)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_left_reg   <= FW'(held_left_reg);
                            out_top_reg    <= FW'(held_top_reg);
                            out_right_reg  <= FW'(held_right_reg);
                            out_bottom_reg <= FW'(held_bottom_reg);
                            out_last_reg   <= 1'b1;
                            held_valid_reg <= 1'b0;
                        end
                        row_reg   <= last_reg ? '0 : row_reg + RW'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_column   = out_left_reg;
    assign top_row       = out_top_reg;
    assign right_column  = out_right_reg;
    assign bottom_row    = out_bottom_reg;
    assign last_of_flush = out_last_reg;

`ifndef SYNTHESIS
    a_held_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (!held_valid_reg || out_free))
        else $error("held rectangle overwritten");

    a_bank_drained: assert property (@(posedge clk) disable iff (!rst_n)
        rel.valid |-> (new_valid_reg[bank_reg] == '0))
        else $error("bank released with runs left");

    a_grid_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (rel.valid && last_reg) |-> (open_valid_reg == '0))
        else $error("rectangle left open after last row");

    a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
        open_we |-> !(rd_en && (rd_col == s_reg)))
        else $error("open table read and write on the same column");
`endif

endmodule

`default_nettype wire

### rtl/tile_grid_rectangle_merger.sv
// ----------------------------------------------------------------------------
// tile_grid_rectangle_merger: merges runs of a binary tile grid into rectangles
// Throughput: one tile beat per cycle while a row streams in, unless the
//   row's run table bank still waits for a flush; every row end starts a
//   flush that walks all MAX_COLUMNS start columns, with an extra step for
//   each column that closes two rectangles. Two run table banks overlap a
//   row's intake with the flush of the row before it.
// Reset: tables empty, grid size 64 by 64; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Structure:
//   front  - takes tile beats, tracks column/row, finds runs and writes them
//            into the run table bank of the current row.
//            At the row end it posts a flush command and flips to the other
//            bank; it stalls intake while that bank still waits for a flush.
//   queue  - two flush commands deep, one per bank.
//   back   - walks start columns 0..MAX_COLUMNS-1 with registered reads of
//            the open rectangle and run RAMs, one column per cycle when it
//            closes at most one rectangle and results can move on. Per column:
//            extend a rectangle whose run matches exactly, else close it,
//            then open the new run; on the last row close all. Closed ones
//            wait in a holding stage so the final one gets last_of_flush,
//            then in the output register; the walk runs on until both fill.

module tile_grid_rectangle_merger #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [tgrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tgrm_pkg::CFG_W-1:0]     cfg_data,
    // tile beats
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           tile_present,
    // rectangle beats
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [tgrm_pkg::OUT_W-1:0]          left_column,
    output logic [tgrm_pkg::OUT_W-1:0]          top_row,
    output logic [tgrm_pkg::OUT_W-1:0]          right_column,
    output logic [tgrm_pkg::OUT_W-1:0]          bottom_row,
    output logic                                last_of_flush
);

    localparam int CW = $clog2(MAX_COLUMNS);

    tgrm_pkg::bank_evt_t  rec;
    logic [CW-1:0]        rec_start;
    logic [CW-1:0]        rec_end;
    logic                 push_valid;
    tgrm_pkg::flush_cmd_t push_cmd;
    logic                 q_valid;
    tgrm_pkg::flush_cmd_t q_cmd;
    logic                 pop;
    tgrm_pkg::bank_evt_t  rel;

    tgrm_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tile_present (tile_present),
        .rec          (rec),
        .rec_start    (rec_start),
        .rec_end      (rec_end),
        .push_valid   (push_valid),
        .push_cmd     (push_cmd),
        .rel          (rel)
    );

    tgrm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    tgrm_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec           (rec),
        .rec_start     (rec_start),
        .rec_end       (rec_end),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .rel           (rel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_column   (left_column),
        .top_row       (top_row),
        .right_column  (right_column),
        .bottom_row    (bottom_row),
        .last_of_flush (last_of_flush)
    );

endmodule

`default_nettype wire

### sim/tile_grid_rectangle_merger_test.sv
// ----------------------------------------------------------------------------
// tile_grid_rectangle_merger_test: self-checking bench of the rectangle merger
// Streams tile beats under random valid/ready idling, rebuilds the merged
// rectangles in a cycle-free model of the block and compares every rectangle
// beat, field by field, in order. A short scripted part goes first, then
// random grids of many sizes, one full 64-column row among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_grid_rectangle_merger_test;

    import tgrm_pkg::*;

    localparam int COLS          = 64;
    localparam int ROWS          = 64;
    // Idle wait before a register write: two queued row flushes can each walk
    // the whole start column table with no output.
    localparam int SETTLE_CYCLES = 4 * COLS + 40;

    // One rectangle beat, in port order.
    typedef struct packed {
        logic [OUT_W-1:0] lcol;
        logic [OUT_W-1:0] trow;
        logic [OUT_W-1:0] rcol;
        logic [OUT_W-1:0] brow;
        logic             last_flag;
    } rect_beat_t;

    typedef enum logic {ST_TILE, ST_REG} step_kind_e;

    // Scripted step: a tile beat (value bit 0 = occupancy) or a register write.
    // When hand_rect is set, the beat closes exactly that one rectangle.
    typedef struct packed {
        step_kind_e           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     value;
        logic                 hand_rect;
        rect_beat_t           rect;
    } script_row_t;

    localparam rect_beat_t NO_RECT = '0;
    localparam int SCRIPT_LEN = 35;

    // reg_idx is a don't-care on tile rows.
    script_row_t script [SCRIPT_LEN] = '{
        // 3 x 2 grid: one full-width block that grows down and closes at grid end
        '{ST_REG,  REG_GRID_WIDTH,  7'd3, 1'b0, NO_RECT},
        '{ST_REG,  REG_GRID_HEIGHT, 7'd2, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b1, '{6'd0, 6'd0, 6'd2, 6'd1, 1'b1}},
        // two single tiles, then a run that matches neither: three closes
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd0, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd0, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        // same start column twice on the last row: old one goes out first
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd0, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        // zero width and height act as 1: every tile is a whole grid
        '{ST_REG,  REG_GRID_WIDTH,  7'd0, 1'b0, NO_RECT},
        '{ST_REG,  REG_GRID_HEIGHT, 7'd0, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b1, '{6'd0, 6'd0, 6'd0, 6'd0, 1'b1}},
        '{ST_TILE, REG_GRID_WIDTH,  7'd0, 1'b0, NO_RECT},
        // width shrinks from 4 to 2 in the middle of row 1
        '{ST_REG,  REG_GRID_WIDTH,  7'd4, 1'b0, NO_RECT},
        '{ST_REG,  REG_GRID_HEIGHT, 7'd3, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd0, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd0, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_REG,  REG_GRID_WIDTH,  7'd2, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b0, NO_RECT},
        '{ST_TILE, REG_GRID_WIDTH,  7'd1, 1'b1, '{6'd0, 6'd0, 6'd1, 6'd2, 1'b1}}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 tile_present;
    logic                 out_valid;
    logic                 out_ready;
    logic [OUT_W-1:0]     left_column;
    logic [OUT_W-1:0]     top_row;
    logic [OUT_W-1:0]     right_column;
    logic [OUT_W-1:0]     bottom_row;
    logic                 last_of_flush;

    tile_grid_rectangle_merger #(
        .MAX_COLUMNS(COLS),
        .MAX_ROWS   (ROWS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tile_present (tile_present),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_column  (left_column),
        .top_row      (top_row),
        .right_column (right_column),
        .bottom_row   (bottom_row),
        .last_of_flush(last_of_flush)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Merge model: raster position, the run in progress, the open
    // rectangles and the runs finished in this row, both by start column.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] grid_w;
    logic [CFG_W-1:0] grid_h;
    int               col_pos;
    int               row_pos;
    bit               run_live;
    int               run_from;
    bit               rect_open [COLS];
    logic [OUT_W-1:0] rect_right [COLS];
    logic [OUT_W-1:0] rect_top [COLS];
    logic [OUT_W-1:0] rect_bot [COLS];
    bit               run_done [COLS];
    logic [OUT_W-1:0] run_end [COLS];

    // Rectangles closed by the latest tile, in closing order.
    rect_beat_t       closed_buf [2*COLS];
    int               closed_count;

    rect_beat_t       rects_due [$];      // rectangles still owed by the block

    function automatic void reset_model();
        int s;
        grid_w   = 7'd64;
        grid_h   = 7'd64;
        col_pos  = 0;
        row_pos  = 0;
        run_live = 1'b0;
        run_from = 0;
        for (s = 0; s < COLS; s++)
        begin
            rect_open[s] = 1'b0;
            run_done[s]  = 1'b0;
        end
    endfunction

    function automatic void note_run(int start, int stop);
        if (start < COLS)
        begin
            run_done[start] = 1'b1;
            run_end[start]  = stop[OUT_W-1:0];
        end
    endfunction

    function automatic void close_rect(int s);
        closed_buf[closed_count] = {s[OUT_W-1:0], rect_top[s], rect_right[s], rect_bot[s], 1'b0};
        closed_count++;
        rect_open[s] = 1'b0;
    endfunction

    function automatic void merge_tile(bit present);
        int w;
        int h;
        int s;
        bit final_row;
        w = (grid_w == 0) ? 1 : ((grid_w > COLS) ? COLS : int'(grid_w));
        h = (grid_h == 0) ? 1 : ((grid_h > ROWS) ? ROWS : int'(grid_h));
        closed_count = 0;
        if (present && !run_live)
        begin
            run_live = 1'b1;
            run_from = col_pos;
        end
        else if (!present && run_live)
        begin
            note_run(run_from, col_pos - 1);
            run_live = 1'b0;
        end
        if (col_pos < w - 1)
        begin
            col_pos++;
            return;
        end
        // row end (also when the width shrank below the current column)
        if (run_live)
        begin
            note_run(run_from, col_pos);
            run_live = 1'b0;
        end
        final_row = (row_pos >= h - 1);
        for (s = 0; s < COLS; s++)
        begin
            if (rect_open[s])
            begin
                if (run_done[s] && run_end[s] == rect_right[s])
                begin
                    rect_bot[s] = row_pos[OUT_W-1:0];
                    run_done[s] = 1'b0;
                end
                else
                    close_rect(s);
            end
            if (run_done[s])
            begin
                rect_open[s]  = 1'b1;
                rect_right[s] = run_end[s];
                rect_top[s]   = row_pos[OUT_W-1:0];
                rect_bot[s]   = row_pos[OUT_W-1:0];
                run_done[s]   = 1'b0;
            end
            if (final_row && rect_open[s])
                close_rect(s);
        end
        col_pos = 0;
        row_pos = final_row ? 0 : row_pos + 1;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: everything is sampled at the rising edge, model first,
    // so a beat accepted on an edge is owed before any output on it.
    // ------------------------------------------------------------------
    int         fault_count   = 0;
    int         tiles_sent    = 0;
    int         rects_checked = 0;
    int         reg_writes    = 0;
    bit         hand_on       = 1'b0;   // next tile beat uses hand_rect
    rect_beat_t hand_rect;

    always @(posedge clk)
    begin : scoreboard
        rect_beat_t got;
        rect_beat_t want;
        int i;
        if (!rst_n)
            reset_model();
        else
        begin
            if (cfg_we)
            begin
                reg_writes++;
                if (cfg_index == REG_GRID_WIDTH)
                    grid_w = cfg_data;
                else if (cfg_index == REG_GRID_HEIGHT)
                    grid_h = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                merge_tile(tile_present);
                tiles_sent++;
                if (hand_on)
                begin
                    rects_due.push_back(hand_rect);
                    hand_on = 1'b0;
                end
                else
                begin
                    for (i = 0; i < closed_count; i++)
                    begin
                        want = closed_buf[i];
                        want.last_flag = (i == closed_count - 1);
                        rects_due.push_back(want);
                    end
                end
            end
            if (out_valid && out_ready)
            begin
                got = {left_column, top_row, right_column, bottom_row, last_of_flush};
                rects_checked++;
                if (rects_due.size() == 0)
                begin
                    $error("rectangle beat with none owed: l=%0d t=%0d r=%0d b=%0d last=%0b",
                           got.lcol, got.trow, got.rcol, got.brow, got.last_flag);
                    fault_count++;
                end
                else
                begin
                    want = rects_due.pop_front();
                    if (got.lcol !== want.lcol)
                    begin
                        $error("left_column: expected %0d, got %0d", want.lcol, got.lcol);
                        fault_count++;
                    end
                    if (got.trow !== want.trow)
                    begin
                        $error("top_row: expected %0d, got %0d", want.trow, got.trow);
                        fault_count++;
                    end
                    if (got.rcol !== want.rcol)
                    begin
                        $error("right_column: expected %0d, got %0d", want.rcol, got.rcol);
                        fault_count++;
                    end
                    if (got.brow !== want.brow)
                    begin
                        $error("bottom_row: expected %0d, got %0d", want.brow, got.brow);
                        fault_count++;
                    end
                    if (got.last_flag !== want.last_flag)
                    begin
                        $error("last_of_flush: expected %0b, got %0b",
                               want.last_flag, got.last_flag);
                        fault_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: out_ready drops in random bursts; quiet turns
    // all idling off for the closing stretch.
    // ------------------------------------------------------------------
    bit quiet     = 1'b0;
    int gap_pct   = 20;     // chance of a sender gap before a beat
    int stall_pct = 20;     // chance of a new receiver stall burst
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (quiet)
        begin
            stall_left = 0;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Sender tasks. Each starts and ends on a falling edge, so every input
    // gets at most one nonblocking write per step.
    // ------------------------------------------------------------------
    task automatic send_tile(input bit present);
        in_valid     <= 1'b1;
        tile_present <= present;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Hold off until every owed rectangle is in, then let a silent flush finish.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (rects_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        in_valid  <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [COLS-1:0] make_mask(int density);
        logic [COLS-1:0] m;
        int c;
        for (c = 0; c < COLS; c++)
            m[c] = ($urandom_range(0, 99) < density);
        return m;
    endfunction

    // Rows mostly repeat the previous pattern so rectangles grow downward;
    // a few tiles are flipped to break runs.
    task automatic play_tiles(input int count, input int density);
        logic [COLS-1:0] row_mask;
        bit p;
        int k;
        row_mask = make_mask(density);
        for (k = 0; k < count; k++)
        begin
            if (!quiet && $urandom_range(0, 99) < 3)
                drain_block();
            else if (!quiet && $urandom_range(0, 99) < gap_pct)
                pause_sender($urandom_range(1, 9));
            if (col_pos == 0 && $urandom_range(0, 99) < 30)
                row_mask = make_mask(density);
            p = row_mask[col_pos];
            if ($urandom_range(0, 99) < 5)
                p = ~p;
            send_tile(p);
        end
    endtask

    // New grid size for a random phase: mostly small, now and then zero or
    // a height of ROWS or more.
    task automatic pick_grid();
        int pick;
        int which;
        which = $urandom_range(0, 3);
        if (which != 1)
        begin
            pick = $urandom_range(0, 99);
            write_reg(REG_GRID_WIDTH, (pick < 10) ? 7'd0 :
                      (pick < 90) ? 7'($urandom_range(1, 8)) : 7'($urandom_range(9, 16)));
        end
        if (which != 2)
        begin
            pick = $urandom_range(0, 99);
            write_reg(REG_GRID_HEIGHT, (pick < 10) ? 7'd0 :
                      (pick < 85) ? 7'($urandom_range(1, 6)) : 7'($urandom_range(64, 127)));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int k;
        int pick;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_GRID_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        tile_present = 1'b0;
        out_ready    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // scripted part
        for (k = 0; k < SCRIPT_LEN; k++)
        begin
            if (script[k].kind == ST_REG)
            begin
                drain_block();
                write_reg(script[k].reg_idx, script[k].value);
            end
            else
            begin
                if ($urandom_range(0, 99) < gap_pct)
                    pause_sender($urandom_range(1, 9));
                hand_on   = script[k].hand_rect;
                hand_rect = script[k].rect;
                send_tile(script[k].value[0]);
            end
        end

        // one full 64-column row (127 clamps to 64), closed at once by height 1
        drain_block();
        write_reg(REG_GRID_WIDTH, 7'd127);
        write_reg(REG_GRID_HEIGHT, 7'd1);
        play_tiles(COLS, 50);

        // random phases; grids may be left half done across a size change
        while (tiles_sent < 180)
        begin
            drain_block();
            pick_grid();
            pick      = $urandom_range(0, 2);
            gap_pct   = (pick == 0) ? 0 : ((pick == 1) ? 25 : 50);
            pick      = $urandom_range(0, 2);
            stall_pct = (pick == 0) ? 0 : ((pick == 1) ? 20 : 50);
            pick      = $urandom_range(0, 3);
            play_tiles($urandom_range(4, 30),
                       (pick == 0) ? 15 : ((pick == 1) ? 50 : ((pick == 2) ? 85 : 100)));
        end

        // closing stretch at full rate on both sides
        drain_block();
        quiet = 1'b1;
        pick_grid();
        play_tiles(20, 60);
        drain_block();

        $display("covered %0d tile beats, %0d rectangle beats, %0d register writes",
                 tiles_sent, rects_checked, reg_writes);
        if (fault_count == 0)
            $display("tile_grid_rectangle_merger: match");
        else
            $display("tile_grid_rectangle_merger: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("timeout with %0d rectangles still owed", rects_due.size());
        $display("tile_grid_rectangle_merger: mismatch");
        $finish;
    end

endmodule
